>>> sv/dvru_pkg.sv
package dvru_pkg;

	// table size, one cell per entry
	localparam int TABLE_ENTRIES = 64;

	localparam logic [7:0] COST_MAX = 8'hFF;

	// one advertised route
	typedef struct packed {
		logic [31:0] neighbor_addr;
		logic [31:0] recv_interface;
		logic [31:0] dest_addr;
		logic [7:0]  adv_cost;
	} in_item_t;

	// outcome of one advertisement
	typedef struct packed {
		logic        table_changed;
		logic        inserted_new;
		logic        dropped_full;
		logic [7:0]  route_cost;
		logic [31:0] route_next_hop;
		logic [31:0] route_interface;
	} result_t;

	// item as it travels along the cell chain
	typedef struct packed {
		logic [31:0] nbr;
		logic [31:0] ifc;
		logic [31:0] dest;
		logic [7:0]  cand;
		logic        claimed;
		logic        changed;
		logic        inserted;
		logic [7:0]  rc;
		logic [31:0] rn;
		logic [31:0] ri;
	} chain_item_t;

	// advertised cost plus one hop, saturating
	function automatic logic [7:0] sat_inc(input logic [7:0] cost);
		sat_inc = (cost == COST_MAX) ? COST_MAX : cost + 8'd1;
	endfunction

endpackage

>>> sv/distance_vector_route_update.sv
// Distance-vector route table update engine.
// Input: an item (neighbour, receiving interface, destination, advertised
// cost) is taken at a rising edge with start high and busy low. busy stays
// low: the table is a chain of TABLE_ENTRIES cells (64) and an item enters
// the first cell every cycle, so one item per cycle is sustained.
// Each cell holds one route and passes the item to the next cell each cycle.
// A cell that holds the destination updates it (cheaper route, or a dearer
// one from the current next hop); the first empty cell reached inserts it.
// Entries fill from cell 0 upwards and are never removed, so an empty cell
// means no later cell holds the destination.
// Output: the result leaves the last cell after passing every cell's stage
// register, shown for one cycle with done high, in input order.
// An item that no cell took is reported as dropped with zero route fields.
// The receiver cannot stall; the result is accepted in its done cycle.
// Reset clears every cell's valid mark at once and empties the chain; there
// is no clearing pass, so items are taken from the first cycle after reset.
module distance_vector_route_update (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  dvru_pkg::in_item_t  item,
	output logic                done,
	output dvru_pkg::result_t   result
);

	logic                  chain_vld  [0:dvru_pkg::TABLE_ENTRIES];
	dvru_pkg::chain_item_t chain_item [0:dvru_pkg::TABLE_ENTRIES];
	logic [dvru_pkg::TABLE_ENTRIES-1:0] occ;
	dvru_pkg::chain_item_t tail;
	dvru_pkg::chain_item_t head;

	// chain accepts every cycle
	assign busy = 1'b0;

	// item entering the first cell
	always_comb begin
		head.nbr      = item.neighbor_addr;
		head.ifc      = item.recv_interface;
		head.dest     = item.dest_addr;
		head.cand     = dvru_pkg::sat_inc(item.adv_cost);
		head.claimed  = 1'b0;
		head.changed  = 1'b0;
		head.inserted = 1'b0;
		head.rc       = 8'd0;
		head.rn       = 32'd0;
		head.ri       = 32'd0;
	end
	assign chain_item[0] = head;
	assign chain_vld[0]  = start & ~busy;

	// row of table cells
	for (genvar i = 0; i < dvru_pkg::TABLE_ENTRIES; i++) begin : g_cell
		dvru_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (chain_vld[i]),
			.in_item  (chain_item[i]),
			.out_vld  (chain_vld[i+1]),
			.out_item (chain_item[i+1]),
			.occupied (occ[i])
		);
	end

	// result from the end of the chain
	assign tail = chain_item[dvru_pkg::TABLE_ENTRIES];
	assign done = chain_vld[dvru_pkg::TABLE_ENTRIES];

	always_comb begin
		result.table_changed   = tail.changed;
		result.inserted_new    = tail.inserted;
		result.dropped_full    = ~tail.claimed;
		result.route_cost      = tail.rc;
		result.route_next_hop  = tail.rn;
		result.route_interface = tail.ri;
	end

	// occupied entries form a prefix of the chain
	a_fill_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(occ & ~{occ[dvru_pkg::TABLE_ENTRIES-2:0], 1'b1}) == '0)
		else $error("occupied entry above an empty one");

	// every result traces back to a start that went through the whole chain
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, dvru_pkg::TABLE_ENTRIES))
		else $error("result without a matching item");

	// a dropped item changes nothing and reports a zero route cost
	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.dropped_full) |->
		(!result.table_changed && !result.inserted_new && result.route_cost == 8'd0))
		else $error("dropped item reports a change");

	// an insertion always counts as a change
	a_insert_changed: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.inserted_new) |-> result.table_changed)
		else $error("insertion not flagged as change");

	// a dropped item only when every entry was in use
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.dropped_full) |-> (occ == '1))
		else $error("item dropped with free entries");

endmodule

>>> sv/dvru_cell.sv
module dvru_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_vld,
	input  dvru_pkg::chain_item_t   in_item,
	output logic                    out_vld,
	output dvru_pkg::chain_item_t   out_item,
	output logic                    occupied
);

	logic                  valid_q;
	logic [31:0]           dest_q;
	logic [7:0]            cost_q;
	logic [31:0]           hop_q;
	logic [31:0]           ifc_q;
	logic                  out_vld_q;
	dvru_pkg::chain_item_t out_item_q;
	dvru_pkg::chain_item_t nxt_item;
	logic                  open_item;
	logic                  hit;
	logic                  take_free;
	logic                  cheaper;
	logic                  dearer;

	// match or claim this entry for an item nobody has handled yet
	assign open_item = in_vld & ~in_item.claimed;
	assign hit       = open_item & valid_q & (dest_q == in_item.dest);
	assign take_free = open_item & ~valid_q;
	assign cheaper   = cost_q > in_item.cand;
	assign dearer    = (cost_q < in_item.cand) & (hop_q == in_item.nbr);

	// item handed on to the next cell
	always_comb begin
		nxt_item = in_item;
		if (hit) begin
			nxt_item.claimed = 1'b1;
			nxt_item.changed = cheaper | dearer;
			nxt_item.rc      = (cheaper | dearer) ? in_item.cand : cost_q;
			nxt_item.rn      = cheaper ? in_item.nbr : hop_q;
			nxt_item.ri      = cheaper ? in_item.ifc : ifc_q;
		end else if (take_free) begin
			nxt_item.claimed  = 1'b1;
			nxt_item.changed  = 1'b1;
			nxt_item.inserted = 1'b1;
			nxt_item.rc       = in_item.cand;
			nxt_item.rn       = in_item.nbr;
			nxt_item.ri       = in_item.ifc;
		end
	end

	// valid mark, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_free) begin
			valid_q <= 1'b1;
		end
	end

	// entry contents
	always_ff @(posedge clk) begin
		if (take_free) begin
			dest_q <= in_item.dest;
			cost_q <= in_item.cand;
			hop_q  <= in_item.nbr;
			ifc_q  <= in_item.ifc;
		end else if (hit && cheaper) begin
			cost_q <= in_item.cand;
			hop_q  <= in_item.nbr;
			ifc_q  <= in_item.ifc;
		end else if (hit && dearer) begin
			cost_q <= in_item.cand;
		end
	end

	// stage register towards the neighbour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		out_item_q <= nxt_item;
	end

	assign out_vld  = out_vld_q;
	assign out_item = out_item_q;
	assign occupied = valid_q;

endmodule

>>> test/route_update_checker.sv
module route_update_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  dvru_pkg::in_item_t item,
	input  logic               done,
	input  dvru_pkg::result_t  result,
	output int                 fail_count,
	output int                 outstanding
);

	timeunit 1ns;
	timeprecision 1ps;

	// shadow copy of the route table
	logic        tbl_valid [dvru_pkg::TABLE_ENTRIES];
	logic [31:0] tbl_dest  [dvru_pkg::TABLE_ENTRIES];
	logic [7:0]  tbl_cost  [dvru_pkg::TABLE_ENTRIES];
	logic [31:0] tbl_hop   [dvru_pkg::TABLE_ENTRIES];
	logic [31:0] tbl_ifc   [dvru_pkg::TABLE_ENTRIES];

	// outcomes still owed by the block, oldest first
	dvru_pkg::result_t predicted_outcomes [$];

	// merge one advertisement into the shadow table and return its outcome
	function automatic dvru_pkg::result_t merge_advert(input dvru_pkg::in_item_t adv);
		dvru_pkg::result_t outcome;
		logic [8:0]  sum;
		logic [7:0]  cand;
		int          hit;
		int          free_slot;
		outcome   = '0;
		sum       = {1'b0, adv.adv_cost} + 9'd1;
		cand      = sum[8] ? 8'hFF : sum[7:0];
		hit       = -1;
		free_slot = -1;
		// lowest matching slot and lowest empty slot
		for (int i = 0; i < dvru_pkg::TABLE_ENTRIES; i++) begin
			if (tbl_valid[i]) begin
				if (hit < 0 && tbl_dest[i] == adv.dest_addr)
					hit = i;
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		if (hit >= 0) begin
			// cheaper route wins outright, dearer only from the current next hop
			if (tbl_cost[hit] > cand) begin
				tbl_cost[hit]         = cand;
				tbl_hop[hit]          = adv.neighbor_addr;
				tbl_ifc[hit]          = adv.recv_interface;
				outcome.table_changed = 1'b1;
			end else if (tbl_cost[hit] < cand && tbl_hop[hit] == adv.neighbor_addr) begin
				tbl_cost[hit]         = cand;
				outcome.table_changed = 1'b1;
			end
			outcome.route_cost      = tbl_cost[hit];
			outcome.route_next_hop  = tbl_hop[hit];
			outcome.route_interface = tbl_ifc[hit];
		end else if (free_slot >= 0) begin
			tbl_valid[free_slot]    = 1'b1;
			tbl_dest[free_slot]     = adv.dest_addr;
			tbl_cost[free_slot]     = cand;
			tbl_hop[free_slot]      = adv.neighbor_addr;
			tbl_ifc[free_slot]      = adv.recv_interface;
			outcome.table_changed   = 1'b1;
			outcome.inserted_new    = 1'b1;
			outcome.route_cost      = cand;
			outcome.route_next_hop  = adv.neighbor_addr;
			outcome.route_interface = adv.recv_interface;
		end else begin
			outcome.dropped_full = 1'b1;
		end
		return outcome;
	endfunction

	// compare results as they leave, predict items as they are taken
	always @(posedge clk) begin
		dvru_pkg::result_t want;
		if (!arst_n) begin
			for (int i = 0; i < dvru_pkg::TABLE_ENTRIES; i++)
				tbl_valid[i] = 1'b0;
			predicted_outcomes.delete();
			fail_count = 0;
		end else begin
			if (done) begin
				if (predicted_outcomes.size() == 0) begin
					$error("result with no item outstanding");
					fail_count++;
				end else begin
					want = predicted_outcomes.pop_front();
					if (result.table_changed !== want.table_changed) begin
						$error("table_changed: expected %0d, actual %0d",
							want.table_changed, result.table_changed);
						fail_count++;
					end
					if (result.inserted_new !== want.inserted_new) begin
						$error("inserted_new: expected %0d, actual %0d",
							want.inserted_new, result.inserted_new);
						fail_count++;
					end
					if (result.dropped_full !== want.dropped_full) begin
						$error("dropped_full: expected %0d, actual %0d",
							want.dropped_full, result.dropped_full);
						fail_count++;
					end
					if (result.route_cost !== want.route_cost) begin
						$error("route_cost: expected %0d, actual %0d",
							want.route_cost, result.route_cost);
						fail_count++;
					end
					if (result.route_next_hop !== want.route_next_hop) begin
						$error("route_next_hop: expected %h, actual %h",
							want.route_next_hop, result.route_next_hop);
						fail_count++;
					end
					if (result.route_interface !== want.route_interface) begin
						$error("route_interface: expected %h, actual %h",
							want.route_interface, result.route_interface);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				predicted_outcomes.insert(predicted_outcomes.size(), merge_advert(item));
		end
		outstanding = predicted_outcomes.size();
	end

endmodule

>>> test/tb_top.sv
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_ITEMS  = 1900;
	localparam int CALM_TAIL   = 200;
	localparam int QUIET_LIMIT = 1000;
	localparam int POOL_DEST   = 72;
	localparam int POOL_NBR    = 6;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	dvru_pkg::in_item_t item;
	logic               done;
	dvru_pkg::result_t  result;
	int                 fail_count;
	int                 outstanding;
	int                 quiet_cycles;

	logic [31:0] dest_pool [POOL_DEST];
	logic [31:0] nbr_pool  [POOL_NBR];

	distance_vector_route_update uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	route_update_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.done        (done),
		.result      (result),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// present one item and hold it until taken
	task automatic advertise(input logic [31:0] nbr, input logic [31:0] ifc,
			input logic [31:0] dst, input logic [7:0] cost);
		dvru_pkg::in_item_t adv;
		adv.neighbor_addr  = nbr;
		adv.recv_interface = ifc;
		adv.dest_addr      = dst;
		adv.adv_cost       = cost;
		start <= 1'b1;
		item  <= adv;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// stall watchdog
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		logic [31:0] nbr;
		logic [31:0] dst;
		logic [7:0]  cost;
		int          reach;
		int          pick;
		arst_n       = 1'b0;
		start        = 1'b0;
		item         = '0;
		for (int i = 0; i < POOL_DEST; i++)
			dest_pool[i] = $urandom;
		nbr_pool[0] = 32'h0000_0000;
		nbr_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_NBR; i++)
			nbr_pool[i] = $urandom;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: cost extremes, saturation, equal, cheaper and dearer routes
		advertise(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 8'd0);
		advertise(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
		advertise(32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_5A5A, 8'd254);
		pause($urandom_range(1, 3));
		advertise(32'hFFFF_FFFF, 32'h0F0F_0F0F, 32'hFFFF_FFFF, 8'd254);
		advertise(32'hFFFF_FFFF, 32'hF0F0_F0F0, 32'hFFFF_FFFF, 8'd10);
		advertise(32'h0000_0000, 32'h5555_5555, 32'hFFFF_FFFF, 8'd20);
		advertise(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 8'd30);
		pause($urandom_range(1, 3));
		advertise(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 8'd30);
		advertise(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 8'd0);
		advertise(32'h0000_0000, 32'h7FFF_FFFF, 32'hA5A5_5A5A, 8'd0);
		advertise(32'h0000_0000, 32'hDEAD_0000, 32'hA5A5_5A5A, 8'd255);
		advertise(32'hFFFF_FFFF, 32'h0000_BEEF, 32'h0000_0000, 8'd255);
		advertise(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 8'd254);
		advertise(32'h1111_1111, 32'h2222_2222, 32'h0000_0000, 8'd3);
		pause($urandom_range(1, 3));

		// random: small destination set first, then enough to fill the table
		for (int n = 0; n < RAND_ITEMS; n++) begin
			reach = (n < 600) ? 40 : POOL_DEST;
			if ($urandom_range(0, 15) == 0)
				dst = $urandom;
			else
				dst = dest_pool[$urandom_range(0, reach - 1)];
			if ($urandom_range(0, 7) == 0)
				nbr = $urandom;
			else
				nbr = nbr_pool[$urandom_range(0, POOL_NBR - 1)];
			// mostly small costs, some wide ones and some at saturation
			pick = int'($urandom_range(0, 7));
			if (pick < 4)
				cost = 8'($urandom_range(0, 15));
			else if (pick < 6)
				cost = 8'($urandom_range(0, 255));
			else if (pick == 6)
				cost = 8'($urandom_range(254, 255));
			else
				cost = 8'd0;
			advertise(nbr, $urandom, dst, cost);
			// gaps in bursts, with calm stretches and none near the end
			if (n < RAND_ITEMS - CALM_TAIL && (n / 150) % 3 != 2
					&& $urandom_range(0, 3) == 0)
				pause($urandom_range(1, 3));
		end
		start <= 1'b0;
		@(posedge clk);

		// drain the pipeline, then let it settle
		wait (outstanding == 0);
		repeat (dvru_pkg::TABLE_ENTRIES + 8) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> files.f
sv/dvru_pkg.sv
sv/dvru_cell.sv
sv/distance_vector_route_update.sv
test/route_update_checker.sv
test/tb_top.sv
